// ----- sv/gbte_pkg.sv -----
// shared types and constants for the gap buffer editor
`default_nettype none
package gbte_pkg;
	localparam int TEXT_CAPACITY = 64;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	typedef enum logic [3:0] {
		FN_INS = 4'd0, FN_DEL = 4'd1, FN_DELWORD = 4'd2, FN_BACK = 4'd3,
		FN_BACKWORD = 4'd4, FN_FWD = 4'd5, FN_FWDWORD = 4'd6, FN_START = 4'd7,
		FN_END = 4'd8, FN_COPY = 4'd9, FN_PASTE = 4'd10, FN_SHOW = 4'd11
	} func_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_WAIT, S_ACT, S_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- sv/gbte_cmd_if.sv -----
// command channel
`default_nettype none
interface gbte_cmd_if;
	logic valid;
	logic ready;
	logic [3:0] func;
	logic [7:0] char_in;
	logic [6:0] copy_count;
	modport source (output valid, func, char_in, copy_count, input ready);
	modport sink (input valid, func, char_in, copy_count, output ready);
endinterface
`default_nettype wire

// ----- sv/gbte_res_if.sv -----
// result channel
`default_nettype none
interface gbte_res_if;
	logic valid;
	logic ready;
	logic [7:0] char_out;
	logic [6:0] cursor_pos;
	logic [6:0] text_length;
	logic [1:0] status;
	logic last;
	modport source (output valid, char_out, cursor_pos, text_length, status, last,
		input ready);
	modport sink (input valid, char_out, cursor_pos, text_length, status, last,
		output ready);
endinterface
`default_nettype wire

// ----- sv/gap_buffer_text_editor_core.sv -----
// gap buffer text editor: two stacks in one memory, a clipboard memory, a sequencer
// insert and delete act at accept; a one-step move reads, waits for the registered memory
// read, then acts; walking commands repeat those steps per character moved, copied or
// pasted, and show gives one result beat per character, every other command one beat;
// one command at a time, as cmd.ready is high only in idle
// reset: cursor, lengths and clipboard length clear; memory contents are not cleared
`default_nettype none
module gap_buffer_text_editor_core #(
	parameter int TEXT_CAPACITY = gbte_pkg::TEXT_CAPACITY
) (
	input wire logic clk,
	input wire logic arst_n,
	gbte_cmd_if.sink cmd,
	gbte_res_if.source res
);
	localparam int AW = $clog2(TEXT_CAPACITY);
	localparam logic [6:0] CAP = 7'(TEXT_CAPACITY);

	gbte_pkg::state_t state_q, state_d;
	logic [3:0] func_q;
	logic [6:0] count_q;
	logic [6:0] front_q, back_q, clip_len_q, idx_q;
	logic [1:0] status_q;
	logic [7:0] text_mem [TEXT_CAPACITY];
	logic [7:0] clip_mem [TEXT_CAPACITY];
	logic [7:0] trd_q, crd_q;
	logic [AW-1:0] raddr, caddr;
	logic [7:0] cout_q;
	logic last_q;

	logic [6:0] total;
	assign total = front_q + back_q;
	logic full;
	assign full = total >= CAP;

	logic cmd_fire;
	assign cmd_fire = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == gbte_pkg::S_IDLE);

	// read address per command step
	always_comb begin
		raddr = '0;
		unique case (func_q)
			gbte_pkg::FN_DELWORD, gbte_pkg::FN_BACKWORD, gbte_pkg::FN_START,
			gbte_pkg::FN_BACK:
				raddr = AW'(front_q - 7'd1);
			gbte_pkg::FN_FWDWORD, gbte_pkg::FN_END, gbte_pkg::FN_FWD:
				raddr = AW'(CAP - back_q);
			gbte_pkg::FN_COPY: raddr = AW'(CAP - back_q + idx_q);
			gbte_pkg::FN_SHOW: raddr = (idx_q < front_q) ? AW'(idx_q)
				: AW'(CAP - total + idx_q);
			default: raddr = '0;
		endcase
		caddr = AW'(idx_q);
	end

	// does this command walk another step
	logic more;
	always_comb begin
		more = 1'b0;
		unique case (func_q)
			gbte_pkg::FN_DELWORD, gbte_pkg::FN_BACKWORD, gbte_pkg::FN_START,
			gbte_pkg::FN_BACK:
				more = front_q != 7'd0;
			gbte_pkg::FN_FWDWORD, gbte_pkg::FN_END, gbte_pkg::FN_FWD:
				more = back_q != 7'd0;
			gbte_pkg::FN_COPY: more = idx_q < count_q;
			gbte_pkg::FN_PASTE: more = idx_q < clip_len_q;
			gbte_pkg::FN_SHOW: more = idx_q < total;
			default: more = 1'b0;
		endcase
	end

	logic stop_space;
	assign stop_space = (func_q == gbte_pkg::FN_DELWORD || func_q == gbte_pkg::FN_BACKWORD
		|| func_q == gbte_pkg::FN_FWDWORD) && trd_q == gbte_pkg::SPACE_CHAR;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbte_pkg::S_IDLE: if (cmd_fire) state_d = gbte_pkg::S_RD;
			gbte_pkg::S_RD: state_d = more ? gbte_pkg::S_WAIT : gbte_pkg::S_OUT;
			gbte_pkg::S_WAIT: state_d = gbte_pkg::S_ACT;
			gbte_pkg::S_ACT: begin
				if (func_q == gbte_pkg::FN_SHOW) state_d = gbte_pkg::S_OUT;
				else if (func_q == gbte_pkg::FN_BACK || func_q == gbte_pkg::FN_FWD)
					state_d = gbte_pkg::S_OUT;
				else if (stop_space) state_d = gbte_pkg::S_OUT;
				else if (func_q == gbte_pkg::FN_PASTE && full) state_d = gbte_pkg::S_OUT;
				else state_d = gbte_pkg::S_RD;
			end
			gbte_pkg::S_OUT: if (res.ready) begin
				if (func_q == gbte_pkg::FN_SHOW && !last_q) state_d = gbte_pkg::S_RD;
				else state_d = gbte_pkg::S_IDLE;
			end
			default: state_d = gbte_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gbte_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// memories
	always_ff @(posedge clk) begin
		trd_q <= text_mem[raddr];
		crd_q <= clip_mem[caddr];
		if (state_q == gbte_pkg::S_IDLE && cmd_fire && cmd.func == gbte_pkg::FN_INS
			&& !full)
			text_mem[AW'(front_q)] <= cmd.char_in;
		if (state_q == gbte_pkg::S_ACT) begin
			unique case (func_q)
				gbte_pkg::FN_BACKWORD, gbte_pkg::FN_START, gbte_pkg::FN_BACK:
					if (!stop_space) text_mem[AW'(CAP - 7'd1 - back_q)] <= trd_q;
				gbte_pkg::FN_FWDWORD, gbte_pkg::FN_END, gbte_pkg::FN_FWD:
					if (!stop_space) text_mem[AW'(front_q)] <= trd_q;
				gbte_pkg::FN_PASTE: if (!full) text_mem[AW'(front_q)] <= crd_q;
				gbte_pkg::FN_COPY: clip_mem[AW'(idx_q)] <= trd_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0; back_q <= '0; clip_len_q <= '0; idx_q <= '0;
			status_q <= gbte_pkg::ST_OK; func_q <= '0; count_q <= '0;
			cout_q <= '0; last_q <= 1'b0;
		end else begin
			unique case (state_q)
				gbte_pkg::S_IDLE: if (cmd_fire) begin
					func_q <= cmd.func; idx_q <= '0;
					count_q <= (cmd.copy_count > back_q) ? back_q : cmd.copy_count;
					status_q <= gbte_pkg::ST_OK; cout_q <= '0; last_q <= 1'b1;
					unique case (cmd.func)
						gbte_pkg::FN_INS: if (full) status_q <= gbte_pkg::ST_FULL;
							else front_q <= front_q + 7'd1;
						gbte_pkg::FN_DEL: if (front_q != 7'd0) front_q <= front_q - 7'd1;
						gbte_pkg::FN_SHOW:
							if (total == 7'd0) status_q <= gbte_pkg::ST_EMPTY;
						default: ;
					endcase
				end
				gbte_pkg::S_RD: if (!more && func_q == gbte_pkg::FN_COPY)
					clip_len_q <= count_q;
				gbte_pkg::S_ACT: begin
					unique case (func_q)
						gbte_pkg::FN_DELWORD: if (!stop_space) front_q <= front_q - 7'd1;
						gbte_pkg::FN_BACKWORD, gbte_pkg::FN_START, gbte_pkg::FN_BACK:
							if (!stop_space) begin
								front_q <= front_q - 7'd1; back_q <= back_q + 7'd1;
							end
						gbte_pkg::FN_FWDWORD, gbte_pkg::FN_END, gbte_pkg::FN_FWD:
							if (!stop_space) begin
								front_q <= front_q + 7'd1; back_q <= back_q - 7'd1;
							end
						gbte_pkg::FN_COPY: idx_q <= idx_q + 7'd1;
						gbte_pkg::FN_PASTE: if (full) status_q <= gbte_pkg::ST_FULL;
							else begin
								front_q <= front_q + 7'd1; idx_q <= idx_q + 7'd1;
							end
						gbte_pkg::FN_SHOW: begin
							cout_q <= trd_q; last_q <= (idx_q + 7'd1) == total;
							idx_q <= idx_q + 7'd1;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign res.valid = state_q == gbte_pkg::S_OUT;
	assign res.char_out = cout_q;
	assign res.cursor_pos = front_q;
	assign res.text_length = total;
	assign res.status = status_q;
	assign res.last = last_q;
endmodule
`default_nettype wire

// ----- verif/tb_gap_buffer_text_editor_core.sv -----
// testbench for the gap buffer editor: command model, scoreboard, random and directed commands
`default_nettype none
module tb_gap_buffer_text_editor_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = gbte_pkg::TEXT_CAPACITY;

	typedef struct packed {
		logic [7:0] ch;
		logic [6:0] cursor;
		logic [6:0] length;
		logic [1:0] status;
		logic last;
	} beat_t;

	class editor_scoreboard;
		logic [7:0] text [CAP];
		logic [7:0] clip [CAP];
		int front_len, back_len, clip_len;
		beat_t pending[$];
		int mismatches;

		function void clear();
			front_len = 0;
			back_len = 0;
			clip_len = 0;
			pending.delete();
			mismatches = 0;
		endfunction

		function void add(logic [7:0] c, logic [1:0] st, logic lst);
			beat_t b;
			b.ch = c;
			b.cursor = front_len[6:0];
			b.length = 7'(front_len + back_len);
			b.status = st;
			b.last = lst;
			pending.push_back(b);
		endfunction

		function bit push(logic [7:0] c);
			if (front_len + back_len >= CAP) return 0;
			text[front_len] = c;
			front_len++;
			return 1;
		endfunction

		function void step_back();
			if (front_len == 0) return;
			text[CAP - 1 - back_len] = text[front_len - 1];
			front_len--;
			back_len++;
		endfunction

		function void step_fwd();
			if (back_len == 0) return;
			text[front_len] = text[CAP - back_len];
			front_len++;
			back_len--;
		endfunction

		// apply one accepted command and queue the beats it should produce
		function void note_command(logic [3:0] fn, logic [7:0] c, logic [6:0] cnt);
			logic [1:0] st;
			int n, k, total;
			st = gbte_pkg::ST_OK;
			n = cnt;
			case (fn)
				gbte_pkg::FN_INS: if (!push(c)) st = gbte_pkg::ST_FULL;
				gbte_pkg::FN_DEL: if (front_len > 0) front_len--;
				gbte_pkg::FN_DELWORD:
					while (front_len > 0 && text[front_len - 1] != gbte_pkg::SPACE_CHAR)
						front_len--;
				gbte_pkg::FN_BACK: step_back();
				gbte_pkg::FN_BACKWORD:
					while (front_len > 0 && text[front_len - 1] != gbte_pkg::SPACE_CHAR)
						step_back();
				gbte_pkg::FN_FWD: step_fwd();
				gbte_pkg::FN_FWDWORD:
					while (back_len > 0 && text[CAP - back_len] != gbte_pkg::SPACE_CHAR)
						step_fwd();
				gbte_pkg::FN_START: while (front_len > 0) step_back();
				gbte_pkg::FN_END: while (back_len > 0) step_fwd();
				gbte_pkg::FN_COPY: begin
					if (n > back_len) n = back_len;
					for (int i = 0; i < n; i++) clip[i] = text[CAP - back_len + i];
					clip_len = n;
				end
				gbte_pkg::FN_PASTE:
					for (int i = 0; i < clip_len; i++)
						if (!push(clip[i])) begin
							st = gbte_pkg::ST_FULL;
							break;
						end
				gbte_pkg::FN_SHOW: begin
					total = front_len + back_len;
					if (total == 0) begin
						add(8'h00, gbte_pkg::ST_EMPTY, 1'b1);
						return;
					end
					k = 0;
					for (int i = 0; i < front_len; i++) begin
						k++;
						add(text[i], gbte_pkg::ST_OK, k == total);
					end
					for (int i = CAP - back_len; i < CAP; i++) begin
						k++;
						add(text[i], gbte_pkg::ST_OK, k == total);
					end
					return;
				end
				default: ;
			endcase
			add(8'h00, st, 1'b1);
		endfunction

		function void check_beat(beat_t got);
			beat_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %p, got %p", exp, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	gbte_cmd_if cmd();
	gbte_res_if res();

	gap_buffer_text_editor_core dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res));

	editor_scoreboard board;
	int cycle_count;
	bit calm;          // no idling on either side
	bit hold_off;      // receiver holds off for a long stretch
	int space_pct;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 2000000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				board.note_command(cmd.func, cmd.char_in, cmd.copy_count);
			if (res.valid && res.ready)
				board.check_beat({res.char_out, res.cursor_pos, res.text_length,
					res.status, res.last});
		end
	end

	// receiver stall pattern, changed at the falling edge
	always @(negedge clk) begin
		if (hold_off) res.ready <= 1'b0;
		else if (calm) res.ready <= 1'b1;
		else res.ready <= ($urandom_range(99) >= 25);
	end

	// valid stays up after a beat until the next send or the final release
	task automatic send(input logic [3:0] fn, input logic [7:0] c, input logic [6:0] cnt);
		if (!calm)
			while ($urandom_range(99) < 25) begin
				cmd.valid <= 1'b0;
				@(negedge clk);
			end
		cmd.valid <= 1'b1;
		cmd.func <= fn;
		cmd.char_in <= c;
		cmd.copy_count <= cnt;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		if ($urandom_range(99) < space_pct) return gbte_pkg::SPACE_CHAR;
		if ($urandom_range(9) == 0) return 8'($urandom_range(255));
		return 8'($urandom_range(8'h61, 8'h7a));
	endfunction

	task automatic random_command();
		int r;
		r = $urandom_range(99);
		if (r < 40) send(gbte_pkg::FN_INS, pick_char(), 7'($urandom_range(127)));
		else if (r < 88) send(4'($urandom_range(gbte_pkg::FN_DEL, gbte_pkg::FN_SHOW)),
			8'($urandom_range(255)), 7'($urandom_range(70)));
		else if (r < 96) send(gbte_pkg::FN_COPY, 8'($urandom_range(255)),
			7'($urandom_range(0, 1) ? $urandom_range(127) : $urandom_range(8)));
		else send(4'($urandom_range(12, 15)), 8'($urandom_range(255)),
			7'($urandom_range(127)));
	endtask

	initial begin
		board = new();
		board.clear();
		calm = 0;
		hold_off = 0;
		space_pct = 15;
		arst_n = 0;
		cmd.valid = 0;
		cmd.func = gbte_pkg::FN_INS;
		cmd.char_in = 0;
		cmd.copy_count = 0;
		res.ready = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty-text edge cases first
		send(gbte_pkg::FN_SHOW, 8'h00, 7'd0);
		send(gbte_pkg::FN_DEL, 8'h00, 7'd0);
		send(gbte_pkg::FN_DELWORD, 8'h00, 7'd0);
		send(gbte_pkg::FN_BACK, 8'h00, 7'd0);
		send(gbte_pkg::FN_FWD, 8'h00, 7'd0);
		send(gbte_pkg::FN_PASTE, 8'h00, 7'd0);
		send(gbte_pkg::FN_INS, 8'hff, 7'h7f);
		send(gbte_pkg::FN_INS, gbte_pkg::SPACE_CHAR, 7'd0);
		send(gbte_pkg::FN_INS, 8'h00, 7'd0);
		send(gbte_pkg::FN_INS, 8'h41, 7'd0);
		send(gbte_pkg::FN_BACKWORD, 8'h00, 7'd0);
		send(gbte_pkg::FN_BACKWORD, 8'h00, 7'd0);
		send(gbte_pkg::FN_FWDWORD, 8'h00, 7'd0);
		send(gbte_pkg::FN_START, 8'h00, 7'd0);
		send(gbte_pkg::FN_COPY, 8'h00, 7'd64);
		send(gbte_pkg::FN_END, 8'h00, 7'd0);
		send(gbte_pkg::FN_DELWORD, 8'h00, 7'd0);
		send(gbte_pkg::FN_PASTE, 8'h00, 7'd0);
		send(gbte_pkg::FN_SHOW, 8'h00, 7'd0);
		send(4'd15, 8'h55, 7'h2a);
		send(gbte_pkg::FN_START, 8'h00, 7'd0);
		send(gbte_pkg::FN_COPY, 8'h00, 7'd0);
		send(gbte_pkg::FN_PASTE, 8'h00, 7'd0);

		// fill to capacity with a calm stretch, then the full-buffer cases
		calm = 1;
		while (board.front_len + board.back_len < CAP)
			send(gbte_pkg::FN_INS, pick_char(), 7'd0);
		send(gbte_pkg::FN_INS, 8'h7e, 7'd0);
		send(gbte_pkg::FN_START, 8'h00, 7'd0);
		send(gbte_pkg::FN_COPY, 8'h00, 7'd100);
		send(gbte_pkg::FN_SHOW, 8'h00, 7'd0);
		send(gbte_pkg::FN_DEL, 8'h00, 7'd0);
		send(gbte_pkg::FN_END, 8'h00, 7'd0);
		repeat (10) send(gbte_pkg::FN_DEL, 8'h00, 7'd0);
		send(gbte_pkg::FN_PASTE, 8'h00, 7'd0);
		calm = 0;

		// receiver holds off while commands keep coming
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			repeat (12) random_command();
		join

		for (int i = 0; i < 260; i++) begin
			space_pct = (i % 80 < 40) ? 20 : 5;
			if (i % 100 == 50) calm = 1;
			if (i % 100 == 80) calm = 0;
			random_command();
		end
		send(gbte_pkg::FN_SHOW, 8'h00, 7'd0);
		cmd.valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
